// ===== hdl/xcs_pkg.sv =====
// ----------------------------------------------------------------------------
// xcs_pkg
// shared codes, types and helpers of the xmodem checksum sender
// ----------------------------------------------------------------------------
package xcs_pkg;

  // default number of data bytes in one block
  localparam int BlockBytesDefault = 128;

  // transaction field widths
  localparam int CmdW    = 3;
  localparam int ByteW   = 8;
  localparam int StatusW = 3;
  localparam int AttW    = 4;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;
  localparam logic [CfgIdxW-1:0] CFG_STRICT_ACK       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SKIP_INITIAL_NAK = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ATTEMPTS     = 2'd2;

  // configuration reset values
  localparam logic            STRICT_ACK_RST       = 1'b1;
  localparam logic            SKIP_INITIAL_NAK_RST = 1'b0;
  localparam logic [AttW-1:0] MAX_ATTEMPTS_RST     = 4'd10;

  // commands
  localparam logic [CmdW-1:0] CMD_START  = 3'd0;
  localparam logic [CmdW-1:0] CMD_LOAD   = 3'd1;
  localparam logic [CmdW-1:0] CMD_SEND   = 3'd2;
  localparam logic [CmdW-1:0] CMD_PULL   = 3'd3;
  localparam logic [CmdW-1:0] CMD_RECV   = 3'd4;
  localparam logic [CmdW-1:0] CMD_FINISH = 3'd5;

  // link control codes
  localparam logic [ByteW-1:0] CODE_SOH = 8'h01;
  localparam logic [ByteW-1:0] CODE_EOT = 8'h04;
  localparam logic [ByteW-1:0] CODE_ACK = 8'h06;
  localparam logic [ByteW-1:0] CODE_NAK = 8'h15;
  localparam logic [ByteW-1:0] CODE_CAN = 8'h18;
  localparam logic [ByteW-1:0] BYTE_ONES = 8'hFF;

  // status codes
  localparam logic [StatusW-1:0] STAT_READY      = 3'd0;
  localparam logic [StatusW-1:0] STAT_WAIT_START = 3'd1;
  localparam logic [StatusW-1:0] STAT_SENDING    = 3'd2;
  localparam logic [StatusW-1:0] STAT_WAIT_REPLY = 3'd3;
  localparam logic [StatusW-1:0] STAT_FINISHING  = 3'd4;
  localparam logic [StatusW-1:0] STAT_DONE       = 3'd5;
  localparam logic [StatusW-1:0] STAT_CANCELLED  = 3'd6;
  localparam logic [StatusW-1:0] STAT_EXHAUSTED  = 3'd7;

  // protocol phase, one-hot
  typedef enum logic [7:0] {
    PH_READY      = 8'b0000_0001,
    PH_WAIT_START = 8'b0000_0010,
    PH_SENDING    = 8'b0000_0100,
    PH_WAIT_REPLY = 8'b0000_1000,
    PH_FINISHING  = 8'b0001_0000,
    PH_DONE       = 8'b0010_0000,
    PH_CANCELLED  = 8'b0100_0000,
    PH_EXHAUSTED  = 8'b1000_0000
  } phase_t;

  // handshake sequencer, one-hot
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } ctrl_state_t;

  // source of the transmitted byte
  typedef enum logic [2:0] {
    TX_NONE = 3'd0,
    TX_SOH  = 3'd1,
    TX_NUM  = 3'd2,
    TX_INV  = 3'd3,
    TX_DATA = 3'd4,
    TX_SUM  = 3'd5,
    TX_EOT  = 3'd6
  } tx_sel_t;

  // controller to datapath
  typedef struct packed {
    logic                start;     // clear block number, positions, attempts
    logic                load_wr;   // write value into the block, advance
    logic                send;      // bump block number, first attempt
    logic                retry;     // next attempt
    logic                fp_inc;    // advance frame position
    logic                fp_clear;  // frame position back to zero
    logic                sum_clear; // restart frame checksum
    logic                rd_issue;  // read the block byte at the frame position
    logic                out_load;  // capture a result
    tx_sel_t             tx_sel;
    logic [StatusW-1:0]  status;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // result register can take a new result
    logic fp_zero;
    logic fp_one;
    logic fp_two;
    logic fp_data;    // frame position inside the data bytes
    logic att_lt_max; // another attempt is allowed
  } dp_stat_t;

  function automatic logic [StatusW-1:0] phase_code(input phase_t ph);
    logic [StatusW-1:0] code;
    case (ph)
      PH_READY:      code = STAT_READY;
      PH_WAIT_START: code = STAT_WAIT_START;
      PH_SENDING:    code = STAT_SENDING;
      PH_WAIT_REPLY: code = STAT_WAIT_REPLY;
      PH_FINISHING:  code = STAT_FINISHING;
      PH_DONE:       code = STAT_DONE;
      PH_CANCELLED:  code = STAT_CANCELLED;
      PH_EXHAUSTED:  code = STAT_EXHAUSTED;
      default:       code = STAT_READY;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/xcs_ram.sv =====
// ----------------------------------------------------------------------------
// xcs_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module xcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/xcs_datapath.sv =====
// ----------------------------------------------------------------------------
// xcs_datapath
// block store, counters, frame checksum and result register
// ----------------------------------------------------------------------------
module xcs_datapath #(
  parameter int BLOCK_BYTES = xcs_pkg::BlockBytesDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  xcs_pkg::ctrl_cmd_t               cmd,
  output xcs_pkg::dp_stat_t                stat,
  input  logic [xcs_pkg::ByteW-1:0]        value,
  input  logic [xcs_pkg::AttW-1:0]         max_attempts,
  input  logic                             m_tready,
  output logic                             out_valid,
  output logic                             tx_valid,
  output logic [xcs_pkg::ByteW-1:0]        tx_byte,
  output logic                             frame_end,
  output logic [xcs_pkg::StatusW-1:0]      status,
  output logic [xcs_pkg::ByteW-1:0]        block_number
);

  localparam int AW      = $clog2(BLOCK_BYTES);
  localparam int FPW     = $clog2(BLOCK_BYTES + 4);
  localparam int DataEnd = BLOCK_BYTES + 3;

  logic [AW-1:0]                 load_pos;
  logic [FPW-1:0]                fp;
  logic [AW-1:0]                 fp_off;
  logic [xcs_pkg::AttW-1:0]      attempts;
  logic [xcs_pkg::ByteW-1:0]     block_count;
  logic [xcs_pkg::ByteW-1:0]     block_count_next;
  logic [xcs_pkg::ByteW-1:0]     frame_sum;
  logic [xcs_pkg::ByteW-1:0]     rd_data;

  assign fp_off = AW'(fp - FPW'(3));

  xcs_ram #(
    .WIDTH (xcs_pkg::ByteW),
    .DEPTH (BLOCK_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (load_pos),
    .wdata (value),
    .re    (cmd.rd_issue),
    .raddr (fp_off),
    .rdata (rd_data)
  );

  always_comb begin
    block_count_next = block_count;
    if (cmd.start) begin
      block_count_next = '0;
    end else if (cmd.send) begin
      block_count_next = block_count + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
      load_pos    <= '0;
      fp          <= '0;
      attempts    <= '0;
      frame_sum   <= '0;
      out_valid   <= 1'b0;
    end else begin
      block_count <= block_count_next;

      if (cmd.start) begin
        load_pos <= '0;
      end else if (cmd.load_wr) begin
        load_pos <= (load_pos == AW'(BLOCK_BYTES - 1)) ? '0 : load_pos + AW'(1);
      end

      if (cmd.start || cmd.fp_clear || cmd.send || cmd.retry) begin
        fp <= '0;
      end else if (cmd.fp_inc) begin
        fp <= fp + FPW'(1);
      end

      if (cmd.start) begin
        attempts <= '0;
      end else if (cmd.send) begin
        attempts <= xcs_pkg::AttW'(1);
      end else if (cmd.retry) begin
        attempts <= attempts + xcs_pkg::AttW'(1);
      end

      // checksum is rebuilt from the data bytes as they leave
      if (cmd.sum_clear) begin
        frame_sum <= '0;
      end else if (cmd.out_load && cmd.tx_sel == xcs_pkg::TX_DATA) begin
        frame_sum <= frame_sum + rd_data;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= cmd.status;
      block_number <= block_count_next;
      case (cmd.tx_sel)
        xcs_pkg::TX_SOH: begin
          tx_valid <= 1'b1; tx_byte <= xcs_pkg::CODE_SOH; frame_end <= 1'b0;
        end
        xcs_pkg::TX_NUM: begin
          tx_valid <= 1'b1; tx_byte <= block_count; frame_end <= 1'b0;
        end
        xcs_pkg::TX_INV: begin
          tx_valid <= 1'b1; tx_byte <= xcs_pkg::BYTE_ONES - block_count; frame_end <= 1'b0;
        end
        xcs_pkg::TX_DATA: begin
          tx_valid <= 1'b1; tx_byte <= rd_data; frame_end <= 1'b0;
        end
        xcs_pkg::TX_SUM: begin
          tx_valid <= 1'b1; tx_byte <= frame_sum; frame_end <= 1'b1;
        end
        xcs_pkg::TX_EOT: begin
          tx_valid <= 1'b1; tx_byte <= xcs_pkg::CODE_EOT; frame_end <= 1'b1;
        end
        default: begin
          tx_valid <= 1'b0; tx_byte <= '0; frame_end <= 1'b0;
        end
      endcase
    end
  end

  assign stat.out_free   = !out_valid || m_tready;
  assign stat.fp_zero    = (fp == FPW'(0));
  assign stat.fp_one     = (fp == FPW'(1));
  assign stat.fp_two     = (fp == FPW'(2));
  assign stat.fp_data    = (fp >= FPW'(3)) && (fp < FPW'(DataEnd));
  assign stat.att_lt_max = (attempts < max_attempts);

  a_load_pos_range: assert property (@(posedge clk) disable iff (rst)
    load_pos <= AW'(BLOCK_BYTES - 1))
    else $error("load position beyond block");

  a_fp_range: assert property (@(posedge clk) disable iff (rst)
    fp <= FPW'(DataEnd))
    else $error("frame position beyond checksum byte");

endmodule

// ===== hdl/xcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// xcs_ctrl
// protocol phase and handshake sequencer of the xmodem sender
// ----------------------------------------------------------------------------
module xcs_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [xcs_pkg::CmdW-1:0]      command,
  input  logic [xcs_pkg::ByteW-1:0]     value,
  input  logic                          strict_ack,
  input  logic                          skip_initial_nak,
  input  xcs_pkg::dp_stat_t             stat,
  output xcs_pkg::ctrl_cmd_t            cmd
);

  xcs_pkg::ctrl_state_t state, state_next;
  xcs_pkg::phase_t      phase, phase_next;
  logic                 fire;

  assign s_tready = (state == xcs_pkg::ST_IDLE) && stat.out_free;
  assign fire     = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    cmd.tx_sel = xcs_pkg::TX_NONE;
    phase_next = phase;
    state_next = state;

    if (state == xcs_pkg::ST_FETCH) begin
      // block ram data is here
      cmd.out_load = 1'b1;
      cmd.tx_sel   = xcs_pkg::TX_DATA;
      state_next   = xcs_pkg::ST_IDLE;
    end else if (fire) begin
      cmd.out_load = 1'b1;
      case (command)
        xcs_pkg::CMD_START: begin
          cmd.start  = 1'b1;
          phase_next = skip_initial_nak ? xcs_pkg::PH_READY : xcs_pkg::PH_WAIT_START;
        end
        xcs_pkg::CMD_LOAD: begin
          cmd.load_wr = (phase == xcs_pkg::PH_READY) || (phase == xcs_pkg::PH_WAIT_START);
        end
        xcs_pkg::CMD_SEND: begin
          if (phase == xcs_pkg::PH_READY) begin
            cmd.send   = 1'b1;
            phase_next = xcs_pkg::PH_SENDING;
          end
        end
        xcs_pkg::CMD_PULL: begin
          if (phase == xcs_pkg::PH_SENDING) begin
            if (stat.fp_zero) begin
              cmd.tx_sel    = xcs_pkg::TX_SOH;
              cmd.sum_clear = 1'b1;
              cmd.fp_inc    = 1'b1;
            end else if (stat.fp_one) begin
              cmd.tx_sel = xcs_pkg::TX_NUM;
              cmd.fp_inc = 1'b1;
            end else if (stat.fp_two) begin
              cmd.tx_sel = xcs_pkg::TX_INV;
              cmd.fp_inc = 1'b1;
            end else if (stat.fp_data) begin
              cmd.rd_issue = 1'b1;
              cmd.fp_inc   = 1'b1;
              cmd.out_load = 1'b0;
              state_next   = xcs_pkg::ST_FETCH;
            end else begin
              cmd.tx_sel   = xcs_pkg::TX_SUM;
              cmd.fp_clear = 1'b1;
              phase_next   = xcs_pkg::PH_WAIT_REPLY;
            end
          end else if (phase == xcs_pkg::PH_FINISHING && stat.fp_zero) begin
            cmd.tx_sel = xcs_pkg::TX_EOT;
            cmd.fp_inc = 1'b1;
          end
        end
        xcs_pkg::CMD_RECV: begin
          if (phase == xcs_pkg::PH_WAIT_START) begin
            if (value == xcs_pkg::CODE_NAK) begin
              phase_next = xcs_pkg::PH_READY;
            end else if (value == xcs_pkg::CODE_CAN) begin
              phase_next = xcs_pkg::PH_CANCELLED;
            end
          end else if (phase == xcs_pkg::PH_WAIT_REPLY) begin
            if (value == xcs_pkg::CODE_ACK) begin
              phase_next = xcs_pkg::PH_READY;
            end else if (value == xcs_pkg::CODE_CAN) begin
              phase_next = xcs_pkg::PH_CANCELLED;
            end else if (value == xcs_pkg::CODE_NAK) begin
              if (stat.att_lt_max) begin
                cmd.retry  = 1'b1;
                phase_next = xcs_pkg::PH_SENDING;
              end else begin
                phase_next = xcs_pkg::PH_EXHAUSTED;
              end
            end else if (!strict_ack) begin
              phase_next = xcs_pkg::PH_READY;
            end
          end else if (phase == xcs_pkg::PH_FINISHING && stat.fp_one) begin
            if (value == xcs_pkg::CODE_ACK) begin
              phase_next = xcs_pkg::PH_DONE;
            end else if (value == xcs_pkg::CODE_CAN) begin
              phase_next = xcs_pkg::PH_CANCELLED;
            end
          end
        end
        xcs_pkg::CMD_FINISH: begin
          if (phase == xcs_pkg::PH_READY) begin
            cmd.fp_clear = 1'b1;
            phase_next   = xcs_pkg::PH_FINISHING;
          end
        end
        default: begin
        end
      endcase
    end

    cmd.status = xcs_pkg::phase_code(phase_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xcs_pkg::ST_IDLE;
      phase <= xcs_pkg::PH_READY;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  a_fetch_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == xcs_pkg::ST_FETCH) |=> (state == xcs_pkg::ST_IDLE))
    else $error("fetch state held longer than one cycle");

  a_fetch_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == xcs_pkg::ST_FETCH) |-> (cmd.out_load && cmd.tx_sel == xcs_pkg::TX_DATA))
    else $error("fetched block byte not captured");

  a_read_only_sending: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> (phase == xcs_pkg::PH_SENDING && stat.out_free))
    else $error("block read outside a frame or with result register busy");

endmodule

// ===== hdl/xmodem_checksum_sender.sv =====
// ----------------------------------------------------------------------------
// xmodem_checksum_sender
// xmodem sender with 8-bit additive checksum and a block ram data store
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser command, tdata value
//  m_*       out        m_tvalid / m_tready  tuser tx_valid, tlast frame_end,
//                                            tdata tx_byte, status, block_number
//  cfg_*     in         cfg_we               cfg_index, cfg_data
//
//  one transaction in gives exactly one transaction out
//  most commands capture their result when accepted; a data byte pull reads the
//  block ram in the idle state and captures its registered output in the fetch state
//  rst is synchronous; the block ram is not cleared and needs no clearing pass
//  s_tready drops while the result register is full and m_tready is low, and
//  in the fetch state of a data pull
// ----------------------------------------------------------------------------
module xmodem_checksum_sender #(
  parameter int BLOCK_BYTES = xcs_pkg::BlockBytesDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] value
  input  logic [2:0]                      s_tuser,   // [2:0] command
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // [7:0] tx_byte, [10:8] status,
                                                     // [18:11] block_number, rest zero
  output logic [0:0]                      m_tuser,   // [0] tx_valid
  output logic                            m_tlast,   // frame_end
  // configuration
  input  logic                            cfg_we,
  input  logic [xcs_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [xcs_pkg::CfgDataW-1:0]    cfg_data
);

  xcs_pkg::ctrl_cmd_t               cmd;
  xcs_pkg::dp_stat_t                stat;

  // configuration registers
  logic                             strict_ack;
  logic                             skip_initial_nak;
  logic [xcs_pkg::AttW-1:0]         max_attempts;

  // result fields
  logic                             tx_valid;
  logic [xcs_pkg::ByteW-1:0]        tx_byte;
  logic                             frame_end;
  logic [xcs_pkg::StatusW-1:0]      status;
  logic [xcs_pkg::ByteW-1:0]        block_number;

  // register writes; an index past the last register is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      strict_ack       <= xcs_pkg::STRICT_ACK_RST;
      skip_initial_nak <= xcs_pkg::SKIP_INITIAL_NAK_RST;
      max_attempts     <= xcs_pkg::MAX_ATTEMPTS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        xcs_pkg::CFG_STRICT_ACK:       strict_ack       <= cfg_data[0];
        xcs_pkg::CFG_SKIP_INITIAL_NAK: skip_initial_nak <= cfg_data[0];
        xcs_pkg::CFG_MAX_ATTEMPTS:     max_attempts     <= cfg_data[xcs_pkg::AttW-1:0];
        default: begin
        end
      endcase
    end
  end

  // phase tracking and transaction sequencing
  xcs_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .command          (s_tuser),
    .value            (s_tdata),
    .strict_ack       (strict_ack),
    .skip_initial_nak (skip_initial_nak),
    .stat             (stat),
    .cmd              (cmd)
  );

  // block store, counters, checksum and result register
  xcs_datapath #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .value        (s_tdata),
    .max_attempts (max_attempts),
    .m_tready     (m_tready),
    .out_valid    (m_tvalid),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .frame_end    (frame_end),
    .status       (status),
    .block_number (block_number)
  );

  // pack the result transaction
  assign m_tdata = {5'b0, block_number, status, tx_byte};
  assign m_tuser = tx_valid;
  assign m_tlast = frame_end;

endmodule
